// File: hdl/bitmap_first_fit_allocator_defines.svh
// assertion macros for the block allocator
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_DEFINES_SVH

// implication checked on every clock edge outside reset
`define BFFA_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// next-cycle implication
`define BFFA_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

// File: hdl/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared constants, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int unsigned BlockCountDef = 8192;
  localparam int unsigned BlockBytesDef = 64;
  localparam logic [15:0] ContMark = 16'hFFFF;

  localparam logic [1:0] ActAlloc = 2'd0;
  localparam logic [1:0] ActFree  = 2'd1;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBadSize  = 3'd1;
  localparam logic [2:0] StNoSpace  = 3'd2;
  localparam logic [2:0] StOutside  = 3'd3;
  localparam logic [2:0] StMisalign = 3'd4;
  localparam logic [2:0] StNotStart = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic clr;       // clearing sweep step
    logic load;      // capture a new item
    logic scan;      // first-fit step over one block
    logic rd;        // read length/used entry at the item's block
    logic chk;       // judge the looked up entry
    logic wr_run;    // write one block of a run, advance
    logic fin;       // publish result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic is_free;
    logic early;     // failure or outcome known at load
    logic found;     // first fit found
    logic scan_end;  // scan is at the last block
    logic run_last;  // current run write is the last
    logic rd_bad;    // looked up entry is not a run start
  } sts_t;

endpackage

// File: hdl/bffa_ctrl.sv
// ----------------------------------------------------------------------------
// bffa_ctrl
// Controller: sequences clear sweep, search, entry read and check, run writes and result.
// ----------------------------------------------------------------------------
module bffa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            out_busy_i,
  input  bffa_pkg::sts_t  sts_i,
  output bffa_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SCAN, S_READ, S_CHECK, S_WRITE, S_DONE
  } state_e;

  state_e state_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o = '0;
    cmd_o.clr    = (state_q == S_CLEAR);
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.rd     = (state_q == S_READ);
    cmd_o.chk    = (state_q == S_CHECK);
    cmd_o.wr_run = (state_q == S_WRITE);
    cmd_o.fin    = (state_q == S_DONE) && !out_busy_i;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      unique case (state_q)
        S_CLEAR: if (sts_i.clr_last) state_q <= S_IDLE;
        S_IDLE:  if (in_valid_i) state_q <= S_DECODE;
        S_DECODE: begin
          if (sts_i.early)         state_q <= S_DONE;
          else if (sts_i.is_alloc) state_q <= S_SCAN;
          else                     state_q <= S_READ;
        end
        S_SCAN: begin
          if (sts_i.found)         state_q <= S_WRITE;
          else if (sts_i.scan_end) state_q <= S_DONE;
        end
        S_READ:  state_q <= S_CHECK;
        S_CHECK: begin
          if (sts_i.rd_bad || !sts_i.is_free) state_q <= S_DONE;
          else                                 state_q <= S_WRITE;
        end
        S_WRITE: if (sts_i.run_last) state_q <= S_DONE;
        S_DONE:  if (!out_busy_i) state_q <= S_IDLE;
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  `include "bitmap_first_fit_allocator_defines.svh"
  `BFFA_ASSERT_IMP(a_load_idle, clk_i, rst_ni, cmd_o.load, state_q == S_IDLE)
  `BFFA_ASSERT_NEXT(a_load_dec, clk_i, rst_ni, cmd_o.load, state_q == S_DECODE)
  `BFFA_ASSERT_IMP(a_one_cmd, clk_i, rst_ni, 1'b1, $onehot0(cmd_o))

endmodule

// File: hdl/bffa_dpath.sv
// ----------------------------------------------------------------------------
// bffa_dpath
// Datapath: used/length memory, search counters, validation, result.
// ----------------------------------------------------------------------------
module bffa_dpath #(
  parameter int unsigned BlockCount = bffa_pkg::BlockCountDef,
  parameter int unsigned BlockBytes = bffa_pkg::BlockBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bffa_pkg::cmd_t cmd_i,
  output bffa_pkg::sts_t sts_o,
  input  logic [1:0]     action_i,
  input  logic [19:0]    request_bytes_i,
  input  logic           pointer_present_i,
  input  logic [19:0]    byte_offset_i,
  output logic           ok_o,
  output logic [2:0]     status_o,
  output logic [18:0]    alloc_offset_o,
  output logic [19:0]    used_bytes_o,
  output logic [19:0]    available_bytes_o
);

  localparam int unsigned AW = $clog2(BlockCount);
  localparam int unsigned CW = $clog2(BlockCount + 1);
  localparam logic [40:0] HeapBytes = 41'(BlockCount) * 41'(BlockBytes);
  localparam logic [20:0] BytesM1 = 21'(BlockBytes - 1);

  // entry: used bit plus 16-bit length
  logic [16:0] mem [BlockCount];
  logic [16:0] rd_q;

  logic [1:0]    act_q;
  logic [19:0]   need_q;     // run length in blocks (>=1 when valid)
  logic [AW-1:0] addr_q;     // sweep / scan / write pointer
  logic [AW-1:0] start_q;
  logic [19:0]   cnt_q;      // free run count, then write index
  logic [CW-1:0] inuse_q;
  logic          ok_q;
  logic [2:0]    st_q;
  logic [18:0]   aoff_q;

  // decode of the new item
  logic [20:0] need_w;
  logic [40:0] boff_w;
  logic        out_w, mis_w, badsz_w;
  assign need_w  = (21'(request_bytes_i) + BytesM1) / 21'(BlockBytes);
  assign boff_w  = 41'(byte_offset_i);
  assign out_w   = !pointer_present_i || (boff_w >= HeapBytes);
  assign mis_w   = (20'(byte_offset_i % BlockBytes) != 20'd0);
  assign badsz_w = (request_bytes_i == 20'd0) || (need_w > 21'(BlockCount)) ||
                   (need_w >= 21'(bffa_pkg::ContMark));

  logic [15:0] len_w;
  assign len_w = rd_q[15:0];

  logic [AW-1:0] blk_w;
  assign blk_w = AW'(byte_offset_i / BlockBytes);

  // used bit of the block at addr_q during scan
  logic mem_used_w;
  assign mem_used_w = rd_q[16];

  // run start, including a run that begins at the current block
  logic [AW-1:0] start_w;
  assign start_w = (cnt_q == 20'd0) ? addr_q : start_q;

  logic scan_hit, last_blk;
  assign last_blk = (32'(addr_q) == BlockCount - 1);
  assign scan_hit = !mem_used_w && ((cnt_q + 20'd1) == need_q);

  // early flags registered at load
  logic early_q;

  always_comb begin
    sts_o = '0;
    sts_o.clr_last = last_blk;
    sts_o.is_alloc = (act_q == bffa_pkg::ActAlloc);
    sts_o.is_free  = (act_q == bffa_pkg::ActFree);
    sts_o.early    = early_q;
    sts_o.found    = scan_hit;
    sts_o.scan_end = last_blk;
    sts_o.run_last = (cnt_q + 20'd1 >= need_q) || last_blk;
    sts_o.rd_bad   = (len_w == 16'd0) || (len_w == bffa_pkg::ContMark) ||
                     (act_q != bffa_pkg::ActFree && !rd_q[16]);
  end

  // read address runs one block ahead while scanning, so rd_q follows addr_q
  logic [AW-1:0] rd_addr;
  always_comb begin
    rd_addr = addr_q;
    if (cmd_i.scan && !scan_hit && !last_blk) rd_addr = addr_q + AW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem[addr_q] <= '0;
    end else if (cmd_i.wr_run) begin
      if (act_q == bffa_pkg::ActAlloc)
        mem[addr_q] <= {1'b1, (cnt_q == 20'd0) ? need_q[15:0] : bffa_pkg::ContMark};
      else
        mem[addr_q] <= '0;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0; cnt_q <= '0; inuse_q <= '0; act_q <= '0;
      need_q <= '0; start_q <= '0; early_q <= 1'b0;
      ok_q <= 1'b0; st_q <= '0; aoff_q <= '0;
    end else begin
      if (cmd_i.clr) addr_q <= addr_q + AW'(1);
      if (cmd_i.load) begin
        act_q   <= action_i;
        need_q  <= need_w[19:0];
        cnt_q   <= '0;
        ok_q    <= 1'b0;
        aoff_q  <= '0;
        if (action_i == bffa_pkg::ActAlloc) begin
          addr_q  <= '0;
          early_q <= badsz_w;
          st_q    <= badsz_w ? bffa_pkg::StBadSize : bffa_pkg::StOk;
        end else begin
          addr_q  <= blk_w;
          early_q <= out_w || mis_w;
          if (out_w)      st_q <= bffa_pkg::StOutside;
          else if (mis_w) st_q <= bffa_pkg::StMisalign;
          else            st_q <= bffa_pkg::StOk;
        end
      end
      // scan: one block per cycle, used bit of addr_q in rd_q
      if (cmd_i.scan) begin
        if (scan_hit) begin
          addr_q <= start_w;
          cnt_q  <= '0;
          ok_q   <= 1'b1;
          aoff_q <= 19'(32'(start_w) * BlockBytes);
        end else begin
          if (mem_used_w) cnt_q <= '0;
          else begin
            if (cnt_q == 20'd0) start_q <= addr_q;
            cnt_q <= cnt_q + 20'd1;
          end
          if (last_blk) st_q <= bffa_pkg::StNoSpace;
          else addr_q <= addr_q + AW'(1);
        end
      end
      // free and check outcome from the looked up entry
      if (cmd_i.chk) begin
        if (sts_o.rd_bad) begin
          st_q <= bffa_pkg::StNotStart;
        end else begin
          ok_q <= 1'b1;
          if (sts_o.is_free) begin
            need_q  <= 20'(len_w);
            inuse_q <= (inuse_q >= CW'(len_w)) ? inuse_q - CW'(len_w) : '0;
          end
        end
      end
      if (cmd_i.wr_run) begin
        cnt_q  <= cnt_q + 20'd1;
        addr_q <= addr_q + AW'(1);
        if (act_q == bffa_pkg::ActAlloc && cnt_q == 20'd0)
          inuse_q <= inuse_q + CW'(need_q);
      end
    end
  end

  // result: taken straight from item registers
  logic [40:0] used_w;
  assign used_w = 41'(inuse_q) * 41'(BlockBytes);
  assign ok_o              = ok_q;
  assign status_o          = st_q;
  assign alloc_offset_o    = aoff_q;
  assign used_bytes_o      = used_w[19:0];
  assign available_bytes_o = (used_w <= HeapBytes) ? 20'(HeapBytes - used_w) : 20'd0;

endmodule

// File: hdl/bitmap_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator
// First-fit block allocator with used bitmap and run length map.
// ----------------------------------------------------------------------------
// channel | direction | handshake
// in      | input     | in_valid_i / in_stall_o
// out     | output    | out_valid_o / out_stall_i
// Each item is decoded after accept; a rejected item goes straight to the result, check
// and free read the entry at the pointer, free then clears its run, and allocate scans
// for the first fit, then writes each block of the run.
// After reset a clearing pass over all BlockCount entries runs before items are taken.
// The next item can be taken in the cycle after the result is issued; a result held by
// out_stall_i stays in the output register and delays only the next result.
module bitmap_first_fit_allocator #(
  parameter int unsigned BlockCount = bffa_pkg::BlockCountDef,
  parameter int unsigned BlockBytes = bffa_pkg::BlockBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [19:0] request_bytes_i,
  input  logic        pointer_present_i,
  input  logic [19:0] byte_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic [2:0]  status_o,
  output logic [18:0] alloc_offset_o,
  output logic [19:0] used_bytes_o,
  output logic [19:0] available_bytes_o
);

  bffa_pkg::cmd_t cmd;
  bffa_pkg::sts_t sts;
  logic           done_q;

  logic        ok_w;
  logic [2:0]  status_w;
  logic [18:0] aoff_w;
  logic [19:0] used_w;
  logic [19:0] avail_w;

  logic        ok_q;
  logic [2:0]  status_q;
  logic [18:0] aoff_q;
  logic [19:0] used_q;
  logic [19:0] avail_q;

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else if (cmd.fin) done_q <= 1'b1;
    else if (!out_stall_i) done_q <= 1'b0;
  end
  assign out_valid_o = done_q;

  // output register, loaded when a result is issued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0; status_q <= '0; aoff_q <= '0; used_q <= '0; avail_q <= '0;
    end else if (cmd.fin) begin
      ok_q     <= ok_w;
      status_q <= status_w;
      aoff_q   <= aoff_w;
      used_q   <= used_w;
      avail_q  <= avail_w;
    end
  end
  assign ok_o              = ok_q;
  assign status_o          = status_q;
  assign alloc_offset_o    = aoff_q;
  assign used_bytes_o      = used_q;
  assign available_bytes_o = avail_q;

  bffa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .out_busy_i (done_q && out_stall_i),
    .sts_i (sts), .cmd_o (cmd)
  );

  bffa_dpath #(.BlockCount(BlockCount), .BlockBytes(BlockBytes)) u_dpath (
    .clk_i, .rst_ni, .cmd_i (cmd), .sts_o (sts),
    .action_i, .request_bytes_i, .pointer_present_i, .byte_offset_i,
    .ok_o (ok_w), .status_o (status_w), .alloc_offset_o (aoff_w),
    .used_bytes_o (used_w), .available_bytes_o (avail_w)
  );

endmodule

// File: tb/sv/bitmap_first_fit_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_test
// Self-checking bench for the first-fit block allocator. A behavioral copy of
// the used bitmap and run length map predicts every result. Directed tests
// cover size, pointer and full-heap cases. A random phase of alloc/free/check
// traffic follows, run with bursty input, random output stalls and one long
// output hold-off.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_test;

  localparam int unsigned NBlk     = bffa_pkg::BlockCountDef;
  localparam int unsigned BBytes   = bffa_pkg::BlockBytesDef;
  localparam int unsigned HeapSize = NBlk * BBytes;
  localparam logic [1:0]  ActCheck = 2'd2;
  localparam logic [1:0]  ActSpare = 2'd3;
  localparam int unsigned CycleLimit = 60000000;

  typedef struct packed {
    logic        ok;
    logic [2:0]  status;
    logic [18:0] aoff;
    logic [19:0] used;
    logic [19:0] avail;
  } alloc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = bffa_pkg::ActAlloc;
  logic [19:0] request_bytes_i = '0;
  logic        pointer_present_i = 1'b0;
  logic [19:0] byte_offset_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        ok_o;
  logic [2:0]  status_o;
  logic [18:0] alloc_offset_o;
  logic [19:0] used_bytes_o;
  logic [19:0] available_bytes_o;

  // heap shadow state
  logic          blk_used [NBlk] = '{default: 1'b0};
  logic [15:0]   blk_len  [NBlk] = '{default: 16'd0};
  int unsigned   blks_in_use = 0;
  alloc_result_t pending_results [$];
  logic [19:0]   live_offsets [$];
  int unsigned   err_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   hold_len = 0;
  bit            burst_gaps;

  bitmap_first_fit_allocator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .request_bytes_i,
    .pointer_present_i, .byte_offset_i, .out_valid_o, .out_stall_i, .ok_o,
    .status_o, .alloc_offset_o, .used_bytes_o, .available_bytes_o
  );

  always #5 clk_i = ~clk_i;

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [2:0] locate_ptr(logic present, logic [19:0] off,
                                            output int unsigned blk);
    blk = 0;
    if (!present || off >= HeapSize) return bffa_pkg::StOutside;
    if (off % BBytes != 0) return bffa_pkg::StMisalign;
    blk = off / BBytes;
    return bffa_pkg::StOk;
  endfunction

  // apply one item to the shadow heap and return its result
  function automatic alloc_result_t heap_step(logic [1:0] act, logic [19:0] req,
                                              logic present, logic [19:0] off);
    alloc_result_t r;
    int unsigned need, start, run, blk, len, used;
    bit found;
    r = '0;
    if (act == bffa_pkg::ActAlloc) begin
      need = (req + BBytes - 1) / BBytes;
      if (req == 0 || need > NBlk || need >= bffa_pkg::ContMark) begin
        r.status = bffa_pkg::StBadSize;
      end else begin
        found = 0;
        run = 0;
        start = 0;
        for (int i = 0; i < NBlk && !found; i++) begin
          if (!blk_used[i]) begin
            if (run == 0) start = i;
            run++;
            if (run == need) found = 1;
          end else begin
            run = 0;
          end
        end
        if (!found) begin
          r.status = bffa_pkg::StNoSpace;
        end else begin
          for (int i = 0; i < need; i++) begin
            blk_used[start + i] = 1'b1;
            blk_len[start + i] = (i == 0) ? 16'(need) : bffa_pkg::ContMark;
          end
          blks_in_use += need;
          r.aoff = 19'(start * BBytes);
          r.ok = 1'b1;
        end
      end
    end else if (act == bffa_pkg::ActFree) begin
      r.status = locate_ptr(present, off, blk);
      if (r.status == bffa_pkg::StOk) begin
        len = blk_len[blk];
        if (len == 0 || len == bffa_pkg::ContMark) begin
          r.status = bffa_pkg::StNotStart;
        end else begin
          for (int i = 0; i < len && blk + i < NBlk; i++) begin
            blk_used[blk + i] = 1'b0;
            blk_len[blk + i] = '0;
          end
          blks_in_use = (blks_in_use >= len) ? blks_in_use - len : 0;
          r.ok = 1'b1;
        end
      end
    end else begin
      // check, and the spare code behaves as check
      r.status = locate_ptr(present, off, blk);
      if (r.status == bffa_pkg::StOk) begin
        len = blk_len[blk];
        if (!blk_used[blk] || len == 0 || len == bffa_pkg::ContMark)
          r.status = bffa_pkg::StNotStart;
        else r.ok = 1'b1;
      end
    end
    used = blks_in_use * BBytes;
    r.used = 20'(used);
    r.avail = 20'((used <= HeapSize) ? HeapSize - used : 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [19:0] got, logic [19:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
             cycle_count);
    err_count++;
  endtask

  // predict on input accept, compare on output accept
  always @(posedge clk_i) begin
    alloc_result_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        exp_r = heap_step(action_i, request_bytes_i, pointer_present_i, byte_offset_i);
        pending_results.push_back(exp_r);
        if (action_i == bffa_pkg::ActAlloc && exp_r.ok)
          live_offsets.push_back(20'(exp_r.aoff));
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected item", 20'(status_o), 20'd0);
        end else begin
          exp_r = pending_results.pop_front();
          if (ok_o !== exp_r.ok) report_mismatch("ok", 20'(ok_o), 20'(exp_r.ok));
          if (status_o !== exp_r.status)
            report_mismatch("status", 20'(status_o), 20'(exp_r.status));
          if (alloc_offset_o !== exp_r.aoff)
            report_mismatch("alloc_offset", 20'(alloc_offset_o), 20'(exp_r.aoff));
          if (used_bytes_o !== exp_r.used)
            report_mismatch("used_bytes", used_bytes_o, exp_r.used);
          if (available_bytes_o !== exp_r.avail)
            report_mismatch("available_bytes", available_bytes_o, exp_r.avail);
        end
      end
    end
  end

  // output stall pattern with one long hold-off, counted here
  always @(posedge clk_i) begin
    int unsigned mode, mode_left, held;
    bit hold_over;
    if (hold_len != 0 && !hold_over) begin
      out_stall_i <= 1'b1;
      held++;
      if (held >= hold_len) hold_over = 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 1) == 1);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // offer one item and wait for it to be taken; called at a rising edge
  task automatic send_item(logic [1:0] act, logic [19:0] req, logic present,
                           logic [19:0] off);
    bit taken;
    int unsigned gap;
    action_i <= act;
    request_bytes_i <= req;
    pointer_present_i <= present;
    byte_offset_i <= off;
    in_valid_i <= 1'b1;
    taken = 0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    if (burst_gaps && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
  endtask

  task automatic test_bad_sizes;
    send_item(bffa_pkg::ActAlloc, 20'd0, 1'b0, 20'd0);
    send_item(bffa_pkg::ActAlloc, 20'(HeapSize + 1), 1'b1, 20'hFFFFF);
    send_item(bffa_pkg::ActAlloc, 20'hFFFFF, 1'b0, 20'd0);
  endtask

  task automatic test_pointer_checks;
    send_item(bffa_pkg::ActAlloc, 20'd100, 1'b0, 20'd0);
    send_item(ActCheck, 20'd0, 1'b1, 20'd0);
    send_item(ActCheck, 20'd0, 1'b1, 20'd64);
    send_item(bffa_pkg::ActFree, 20'd0, 1'b1, 20'd64);
    send_item(ActCheck, 20'd0, 1'b1, 20'd1);
    send_item(bffa_pkg::ActFree, 20'd0, 1'b1, 20'd65);
    send_item(bffa_pkg::ActFree, 20'd0, 1'b1, 20'(HeapSize));
    send_item(ActCheck, 20'd0, 1'b1, 20'hFFFFF);
    send_item(ActCheck, 20'd0, 1'b0, 20'd0);
    send_item(bffa_pkg::ActFree, 20'd0, 1'b0, 20'd0);
    send_item(ActSpare, 20'hFFFFF, 1'b1, 20'd0);
    send_item(bffa_pkg::ActFree, 20'd0, 1'b1, 20'd0);
    send_item(bffa_pkg::ActFree, 20'd0, 1'b1, 20'd0);
    send_item(ActCheck, 20'd0, 1'b1, 20'd0);
    send_item(bffa_pkg::ActFree, 20'd0, 1'b1, 20'd128);
  endtask

  task automatic test_full_heap;
    // whole heap, then no space, then the highest possible offset
    send_item(bffa_pkg::ActAlloc, 20'(HeapSize), 1'b0, 20'd0);
    send_item(bffa_pkg::ActAlloc, 20'd1, 1'b0, 20'd0);
    send_item(bffa_pkg::ActFree, 20'd0, 1'b1, 20'd0);
    send_item(bffa_pkg::ActAlloc, 20'(HeapSize - BBytes), 1'b0, 20'd0);
    send_item(bffa_pkg::ActAlloc, 20'd1, 1'b0, 20'd0);
    send_item(ActCheck, 20'd0, 1'b1, 20'(HeapSize - BBytes));
    send_item(bffa_pkg::ActFree, 20'd0, 1'b1, 20'd0);
    send_item(bffa_pkg::ActFree, 20'd0, 1'b1, 20'(HeapSize - BBytes));
    drain();
    live_offsets.delete();
  endtask

  // mostly well-formed traffic on live runs, some noise
  task automatic test_random(int unsigned count);
    int unsigned pick, idx, sz;
    logic [19:0] off;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (blks_in_use > 2000 && pick < 45) pick = 50;
      if (live_offsets.size() == 0 && pick >= 45 && pick < 85) pick = 0;
      if (pick < 2) begin
        send_item(bffa_pkg::ActAlloc, 20'($urandom_range(1, HeapSize + 4096)), 1'b0,
                  20'd0);
      end else if (pick < 45) begin
        sz = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8192) : $urandom_range(1, 1024);
        send_item(bffa_pkg::ActAlloc, 20'(sz), 1'($urandom), 20'($urandom));
      end else if (pick < 75) begin
        idx = $urandom_range(0, live_offsets.size() - 1);
        off = live_offsets[idx];
        live_offsets.delete(idx);
        send_item(bffa_pkg::ActFree, 20'($urandom), 1'b1, off);
      end else if (pick < 85) begin
        idx = $urandom_range(0, live_offsets.size() - 1);
        off = live_offsets[idx] + (($urandom_range(0, 3) == 0) ? 20'd64 : 20'd0);
        send_item(ActCheck, 20'($urandom), 1'b1, off);
      end else if (pick < 92) begin
        send_item(2'($urandom_range(1, 3)), 20'($urandom), 1'($urandom), 20'($urandom));
      end else begin
        send_item(2'($urandom), 20'($urandom), 1'($urandom),
                  20'($urandom_range(0, HeapSize / 8)));
      end
    end
  endtask

  task automatic test_backpressure;
    hold_len = 3000;
    for (int n = 0; n < 20; n++)
      send_item(ActCheck, 20'($urandom), 1'b1, 20'($urandom_range(0, 63) * BBytes));
    test_random(10);
  endtask

  initial begin
    burst_gaps = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bad_sizes();
    test_pointer_checks();
    test_full_heap();
    burst_gaps = 1'b1;
    test_random(560);
    test_backpressure();
    drain();
    repeat (NBlk + 50) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
